>>> sv/ogbp_pkg.sv
// Shared constants, codes and widths for the occupancy grid boundary point core.
package ogbp_pkg;

  localparam int MAX_COLS  = 512;
  localparam int MAX_ROWS  = 512;
  localparam int DEPTH     = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W    = $clog2(DEPTH);

  localparam int ROW_W     = 9;
  localparam int COL_W     = 9;
  localparam int CELL_W    = 8;
  localparam int THR_W     = 7;
  localparam int DIMCFG_W  = 10;
  localparam int COORD_W   = 32;
  localparam int FACE_W    = 3;
  localparam int DIM_W     = 16;

  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;

  localparam int HALF_W    = ((ROW_W > COL_W) ? ROW_W : COL_W) + 2;
  localparam int PROD_W    = HALF_W + COORD_W;
  localparam int ACC_W     = PROD_W + 4;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOUND_MODE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RES_COS     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RES_SIN     = 3'd7;

  localparam logic [DIMCFG_W-1:0] GRID_WIDTH_RST  = 10'd512;
  localparam logic [DIMCFG_W-1:0] GRID_HEIGHT_RST = 10'd512;
  localparam logic [THR_W-1:0]    THRESHOLD_RST   = 7'd50;
  localparam logic                BOUND_MODE_RST  = 1'b1;
  localparam logic [COORD_W-1:0]  RES_COS_RST     = 32'd3277;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic [FACE_W-1:0] FACE_NONE   = 3'd0;
  localparam logic [FACE_W-1:0] FACE_RIGHT  = 3'd0;
  localparam logic [FACE_W-1:0] FACE_LEFT   = 3'd1;
  localparam logic [FACE_W-1:0] FACE_UP     = 3'd2;
  localparam logic [FACE_W-1:0] FACE_DOWN   = 3'd3;
  localparam logic [FACE_W-1:0] FACE_CENTRE = 3'd4;

endpackage

>>> sv/ogbp_if.sv
// Valid/ready channel interfaces for request and result beats.
interface ogbp_req_if;
  logic                                valid;
  logic                                ready;
  logic                                req_type;
  logic        [ogbp_pkg::ROW_W-1:0]   cell_row;
  logic        [ogbp_pkg::COL_W-1:0]   cell_col;
  logic signed [ogbp_pkg::CELL_W-1:0]  cell_value;

  modport source (output valid, req_type, cell_row, cell_col, cell_value, input ready);
  modport sink   (input valid, req_type, cell_row, cell_col, cell_value, output ready);
endinterface

interface ogbp_res_if;
  logic                                valid;
  logic                                ready;
  logic                                has_point;
  logic signed [ogbp_pkg::COORD_W-1:0] point_x;
  logic signed [ogbp_pkg::COORD_W-1:0] point_y;
  logic        [ogbp_pkg::FACE_W-1:0]  face;
  logic                                last;

  modport source (output valid, has_point, point_x, point_y, face, last, input ready);
  modport sink   (input valid, has_point, point_x, point_y, face, last, output ready);
endinterface

>>> sv/occupancy_grid_boundary_points_core.sv
// Occupancy grid boundary point core: grid memory, neighbour sequencer, point datapath.
// Write beat: accepted back to back; it gives no result.
// Query beat: 5 reads through the single memory read port plus a prep step; then
//   one result per cycle while the result port is ready (1 to 4 results).
//   The output register lets the next beat in early.
// Reset: control and configuration registers go to defaults; grid contents are
//   undefined until written.
module occupancy_grid_boundary_points_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ogbp_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ogbp_pkg::CFG_W-1:0]        cfg_wdata_i,
  ogbp_req_if.sink                          req_i,
  ogbp_res_if.source                        res_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_LAST = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  localparam int ADDR_W  = ogbp_pkg::ADDR_W;
  localparam int ACC_W   = ogbp_pkg::ACC_W;
  localparam int PROD_W  = ogbp_pkg::PROD_W;
  localparam int HALF_W  = ogbp_pkg::HALF_W;
  localparam int COORD_W = ogbp_pkg::COORD_W;
  localparam int DIM_W   = ogbp_pkg::DIM_W;

  function automatic logic [COORD_W-1:0] floor_sat(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] q;
    logic [COORD_W-1:0]      r;
    q = v >>> 1;
    if ((&q[ACC_W-1:COORD_W-1]) || !(|q[ACC_W-1:COORD_W-1])) begin
      r = q[COORD_W-1:0];
    end else if (q[ACC_W-1]) begin
      r = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(COORD_W-1){1'b1}}};
    end
    return r;
  endfunction

  // configuration
  logic [ogbp_pkg::DIMCFG_W-1:0] grid_width_q, grid_height_q;
  logic [ogbp_pkg::THR_W-1:0]    thr_q;
  logic                          bmode_q;
  logic signed [COORD_W-1:0]     origin_x_q, origin_y_q, res_cos_q, res_sin_q;

  // control
  logic [1:0] state_q;
  logic [2:0] k_q;
  logic [3:0] pend_q;
  logic       ctr_q;
  logic       out_valid_q;

  // datapath
  logic [ogbp_pkg::ROW_W-1:0]    row_q;
  logic [ogbp_pkg::COL_W-1:0]    col_q;
  logic signed [PROD_W-1:0]      mul_q [4];
  logic [ogbp_pkg::CELL_W-1:0]   nbv_q [4];
  logic signed [ACC_W-1:0]       x0_q, y0_q;
  logic                          out_has_q, out_last_q;
  logic [COORD_W-1:0]            out_x_q, out_y_q;
  logic [ogbp_pkg::FACE_W-1:0]   out_face_q;

  // grid memory
  logic [ogbp_pkg::CELL_W-1:0]   cell_mem_q [ogbp_pkg::DEPTH];
  logic [ogbp_pkg::CELL_W-1:0]   rdata_q;
  logic [ADDR_W-1:0]             waddr, raddr, caddr;
  logic                          mem_we;

  logic req_acc, out_free, emit_load;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || res_o.ready;
  assign emit_load   = (state_q == S_EMIT) && out_free;

  assign waddr  = ADDR_W'(req_i.cell_row) * ADDR_W'(ogbp_pkg::MAX_COLS)
                + ADDR_W'(req_i.cell_col);
  assign mem_we = req_acc && (req_i.req_type == ogbp_pkg::REQ_WRITE)
               && (DIM_W'(req_i.cell_row) < DIM_W'(ogbp_pkg::MAX_ROWS))
               && (DIM_W'(req_i.cell_col) < DIM_W'(ogbp_pkg::MAX_COLS));

  assign caddr = ADDR_W'(row_q) * ADDR_W'(ogbp_pkg::MAX_COLS) + ADDR_W'(col_q);

  always_comb begin
    case (k_q)
      3'd1:    raddr = caddr + ADDR_W'(1);
      3'd2:    raddr = caddr - ADDR_W'(1);
      3'd3:    raddr = caddr + ADDR_W'(ogbp_pkg::MAX_COLS);
      3'd4:    raddr = caddr - ADDR_W'(ogbp_pkg::MAX_COLS);
      default: raddr = caddr;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cell_mem_q[waddr] <= req_i.cell_value;
    end
    rdata_q <= cell_mem_q[raddr];
  end

  // shared multiplier: cx*rc, cy*rs, cx*rs, cy*rc
  logic signed [HALF_W-1:0]  cx, cy, mul_a;
  logic signed [COORD_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;

  assign cx    = $signed({{(HALF_W-ogbp_pkg::COL_W-1){1'b0}}, col_q, 1'b1});
  assign cy    = $signed({{(HALF_W-ogbp_pkg::ROW_W-1){1'b0}}, row_q, 1'b1});
  assign mul_a = k_q[0] ? cy : cx;
  assign mul_b = (k_q[0] ^ k_q[1]) ? res_sin_q : res_cos_q;
  assign mul_p = mul_a * mul_b;

  logic [1:0] nb_idx;
  assign nb_idx = k_q[1:0] - 2'd1;

  // neighbour classification
  logic [DIM_W-1:0] eff_w, eff_h;
  logic             in_map, occ;
  logic [3:0]       off_map, nb_free;
  logic [ogbp_pkg::CELL_W-1:0] nb_val [4];

  assign eff_w = (DIM_W'(grid_width_q) > DIM_W'(ogbp_pkg::MAX_COLS))
               ? DIM_W'(ogbp_pkg::MAX_COLS) : DIM_W'(grid_width_q);
  assign eff_h = (DIM_W'(grid_height_q) > DIM_W'(ogbp_pkg::MAX_ROWS))
               ? DIM_W'(ogbp_pkg::MAX_ROWS) : DIM_W'(grid_height_q);

  assign in_map = (DIM_W'(row_q) < eff_h) && (DIM_W'(col_q) < eff_w);
  assign occ    = in_map && !nbv_q[0][ogbp_pkg::CELL_W-1]
               && (nbv_q[0][ogbp_pkg::THR_W-1:0] >= thr_q);

  assign off_map[0] = (DIM_W'(col_q) + DIM_W'(1)) >= eff_w;
  assign off_map[1] = (col_q == '0);
  assign off_map[2] = (DIM_W'(row_q) + DIM_W'(1)) >= eff_h;
  assign off_map[3] = (row_q == '0);

  assign nb_val[0] = nbv_q[1];
  assign nb_val[1] = nbv_q[2];
  assign nb_val[2] = nbv_q[3];
  assign nb_val[3] = rdata_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      nb_free[i] = off_map[i] || (!nb_val[i][ogbp_pkg::CELL_W-1]
                                  && (nb_val[i][ogbp_pkg::THR_W-1:0] < thr_q));
    end
  end

  // point selection
  logic signed [ACC_W-1:0] rc_e, rs_e, dx, dy;
  logic [ogbp_pkg::FACE_W-1:0] sel_face;
  logic [3:0] sel_bit;
  logic       sel_has, sel_last;

  assign rc_e = ACC_W'(res_cos_q);
  assign rs_e = ACC_W'(res_sin_q);

  always_comb begin
    sel_face = ogbp_pkg::FACE_NONE;
    sel_bit  = 4'b0000;
    sel_has  = 1'b1;
    dx       = '0;
    dy       = '0;
    priority if (ctr_q) begin
      sel_face = ogbp_pkg::FACE_CENTRE;
    end else if (pend_q[0]) begin
      sel_face = ogbp_pkg::FACE_RIGHT;
      sel_bit  = 4'b0001;
      dx       = rc_e;
      dy       = rs_e;
    end else if (pend_q[1]) begin
      sel_face = ogbp_pkg::FACE_LEFT;
      sel_bit  = 4'b0010;
      dx       = -rc_e;
      dy       = -rs_e;
    end else if (pend_q[2]) begin
      sel_face = ogbp_pkg::FACE_UP;
      sel_bit  = 4'b0100;
      dx       = -rs_e;
      dy       = rc_e;
    end else if (pend_q[3]) begin
      sel_face = ogbp_pkg::FACE_DOWN;
      sel_bit  = 4'b1000;
      dx       = rs_e;
      dy       = -rc_e;
    end else begin
      sel_has  = 1'b0;
    end
    sel_last = ((pend_q & ~sel_bit) == 4'b0000) || ctr_q;
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= ogbp_pkg::GRID_WIDTH_RST;
      grid_height_q <= ogbp_pkg::GRID_HEIGHT_RST;
      thr_q         <= ogbp_pkg::THRESHOLD_RST;
      bmode_q       <= ogbp_pkg::BOUND_MODE_RST;
      origin_x_q    <= '0;
      origin_y_q    <= '0;
      res_cos_q     <= ogbp_pkg::RES_COS_RST;
      res_sin_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ogbp_pkg::REG_GRID_WIDTH:  grid_width_q  <= cfg_wdata_i[ogbp_pkg::DIMCFG_W-1:0];
        ogbp_pkg::REG_GRID_HEIGHT: grid_height_q <= cfg_wdata_i[ogbp_pkg::DIMCFG_W-1:0];
        ogbp_pkg::REG_THRESHOLD:   thr_q         <= cfg_wdata_i[ogbp_pkg::THR_W-1:0];
        ogbp_pkg::REG_BOUND_MODE:  bmode_q       <= cfg_wdata_i[0];
        ogbp_pkg::REG_ORIGIN_X:    origin_x_q    <= cfg_wdata_i;
        ogbp_pkg::REG_ORIGIN_Y:    origin_y_q    <= cfg_wdata_i;
        ogbp_pkg::REG_RES_COS:     res_cos_q     <= cfg_wdata_i;
        ogbp_pkg::REG_RES_SIN:     res_sin_q     <= cfg_wdata_i;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= '0;
      pend_q      <= '0;
      ctr_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit_load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (req_acc && (req_i.req_type == ogbp_pkg::REQ_QUERY)) begin
            k_q     <= '0;
            state_q <= S_READ;
          end
        end
        S_READ: begin
          k_q <= k_q + 3'd1;
          if (k_q == 3'd4) begin
            state_q <= S_LAST;
          end
        end
        S_LAST: begin
          pend_q  <= (occ && bmode_q) ? nb_free : 4'b0000;
          ctr_q   <= occ && !bmode_q;
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            pend_q <= pend_q & ~sel_bit;
            if (sel_last) begin
              ctr_q   <= 1'b0;
              state_q <= S_IDLE;
            end
          end
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      row_q <= req_i.cell_row;
      col_q <= req_i.cell_col;
    end
    if (state_q == S_READ) begin
      if (k_q != 3'd4) begin
        mul_q[k_q[1:0]] <= mul_p;
      end
      if (k_q != 3'd0) begin
        nbv_q[nb_idx] <= rdata_q;
      end
    end
    if (state_q == S_LAST) begin
      x0_q <= ACC_W'(mul_q[0]) - ACC_W'(mul_q[1]) + (ACC_W'(origin_x_q) <<< 1);
      y0_q <= ACC_W'(mul_q[2]) + ACC_W'(mul_q[3]) + (ACC_W'(origin_y_q) <<< 1);
    end
    if (emit_load) begin
      out_has_q  <= sel_has;
      out_face_q <= sel_face;
      out_last_q <= sel_last;
      out_x_q    <= sel_has ? floor_sat(x0_q + dx) : '0;
      out_y_q    <= sel_has ? floor_sat(y0_q + dy) : '0;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.has_point = out_has_q;
  assign res_o.point_x   = out_x_q;
  assign res_o.point_y   = out_y_q;
  assign res_o.face      = out_face_q;
  assign res_o.last      = out_last_q;

endmodule

>>> sv/ogbp_checker.sv
// Port-level assertions for the boundary point core, with its bind.
module ogbp_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           req_valid_i,
  input logic                           req_ready_i,
  input logic                           req_type_i,
  input logic                           res_valid_i,
  input logic                           res_ready_i,
  input logic                           res_has_point_i,
  input logic [ogbp_pkg::COORD_W-1:0]   res_point_x_i,
  input logic [ogbp_pkg::FACE_W-1:0]    res_face_i,
  input logic                           res_last_i
);

  logic req_beat;
  assign req_beat = req_valid_i && req_ready_i;

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_point_x_i)
                                    && $stable(res_face_i) && $stable(res_last_i))
    else $error("result beat changed while stalled");

  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_has_point_i |-> res_last_i && (res_face_i == ogbp_pkg::FACE_NONE)
                                        && (res_point_x_i == '0))
    else $error("empty result not a lone final beat");

  a_centre_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_face_i == ogbp_pkg::FACE_CENTRE) |-> res_has_point_i && res_last_i)
    else $error("centre point must be the only result of a query");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_beat && (req_type_i == ogbp_pkg::REQ_QUERY) |=> !req_ready_i)
    else $error("request taken while query reads are running");

  a_write_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_beat && (req_type_i == ogbp_pkg::REQ_WRITE) |=> req_ready_i)
    else $error("cell write did not complete in one cycle");

endmodule

bind occupancy_grid_boundary_points_core ogbp_checker u_ogbp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .req_type_i      (req_i.req_type),
  .res_valid_i     (res_o.valid),
  .res_ready_i     (res_o.ready),
  .res_has_point_i (res_o.has_point),
  .res_point_x_i   (res_o.point_x),
  .res_face_i      (res_o.face),
  .res_last_i      (res_o.last)
);
